// File: rtl/gldp_pkg.sv
// Shared constants and the result word type of the grid local peak detector.
package gldp_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_COLS_DEF    = 1024;
	localparam int MAX_ROWS_DEF    = 1024;
	localparam int HEIGHT_BITS_DEF = 16;

	// Width of the grid size registers and of the coordinate fields
	localparam int DIM_W    = 11;
	// Grid size after reset
	localparam int GRID_RST = 1024;

	// Result queue: depth (power of two) and most results one cell can cause
	localparam int QUEUE_DEPTH  = 16;
	localparam int RES_PER_ITEM = 3;

	// One result word
	typedef struct packed {
		logic             kind;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic             none_found;
		logic             last;
	} gldp_res_t;

endpackage

// File: rtl/grid_local_peak_detector_unit.sv
// Top level of the grid local peak detector: counters, window, peak tests and ports.
//
// Cells enter one per clock in raster order, followed by one flush word per column; the
// block sustains one input word per cycle, set by the single read and single write per
// cycle of the line buffer memory that holds the two previous rows. A word is read from
// the line buffer on acceptance, the 3x3 window shifts in the next cycle and the peak tests
// run in the cycle after that, at whose end the results enter the output queue. Results
// leave the 16-word queue one per cycle while m_tready is high; input is held back while
// the queue lacks room for three results for each word still in flight, which only
// happens when the output side stalls. The line buffer needs no clearing after reset.
module grid_local_peak_detector_unit
	import gldp_pkg::*;
#(
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((HEIGHT_BITS+7)/8)*8-1:0]    s_tdata,  // height
	input  logic [0:0]                          s_tuser,  // action
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,  // peak_row, peak_col, none_found
	output logic [0:0]                          m_tuser,  // kind
	output logic                                m_tlast,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W    = $clog2(MAX_COLS + 1);
	localparam int ROW_W    = $clog2(MAX_ROWS + 1);
	localparam int LVL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ROWS_RST = (GRID_RST > MAX_ROWS) ? MAX_ROWS : GRID_RST;
	localparam int COLS_RST = (GRID_RST > MAX_COLS) ? MAX_COLS : GRID_RST;

	localparam logic REG_ROWS  = 1'b0;
	localparam logic REG_COLS  = 1'b1;
	localparam logic ACT_FLUSH = 1'b1;
	localparam logic KIND_PEAK = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Configuration
	logic [DIM_W-1:0] grid_rows_q;
	logic [DIM_W-1:0] grid_cols_q;
	logic [ROW_W-1:0] rows_eff_q;
	logic [CNT_W-1:0] cols_eff_q;
	logic             cfg_wr;

	// Input stage
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             flush_in;
	logic             data_phase;
	logic             take;
	logic [CNT_W-1:0] col_next;
	logic             row_end;
	logic             final_in;
	logic signed [HEIGHT_BITS-1:0] bottom_in;

	// Window stage
	logic             v_s1;
	logic             flush_s1;
	logic             row_end_s1;
	logic             final_s1;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] row_s1;
	logic signed [HEIGHT_BITS-1:0] bottom_s1;
	logic [2*HEIGHT_BITS-1:0]      lb_rd;
	logic signed [HEIGHT_BITS-1:0] two_above;
	logic signed [HEIGHT_BITS-1:0] above;
	logic signed [HEIGHT_BITS-1:0] win_q [3][3];  // [column][row]

	// Test stage
	logic             v_s2;
	logic             flush_s2;
	logic             row_end_s2;
	logic             final_s2;
	logic [COL_W-1:0] c_s2;
	logic [ROW_W-1:0] row_s2;
	logic             peak_a;
	logic             peak_b;
	logic             hit_a;
	logic             hit_b;
	logic             end_hit;
	logic             has_t;
	logic             peak_seen_q;
	gldp_res_t        res_a;
	gldp_res_t        res_b;
	gldp_res_t        res_e;
	gldp_res_t        push_data [RES_PER_ITEM];
	logic [1:0]       push_cnt;

	// Output side
	gldp_res_t        head;
	logic [LVL_W-1:0] q_level;
	logic             pop;

	// Register writes and reads
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= DIM_W'(GRID_RST);
			grid_cols_q <= DIM_W'(GRID_RST);
			rows_eff_q  <= ROW_W'(ROWS_RST);
			cols_eff_q  <= CNT_W'(COLS_RST);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: begin
					grid_rows_q <= pwdata[DIM_W-1:0];
					rows_eff_q  <= (pwdata[DIM_W-1:0] == '0) ? ROW_W'(1) :
						(32'(pwdata[DIM_W-1:0]) > MAX_ROWS) ? ROW_W'(MAX_ROWS) :
						ROW_W'(pwdata[DIM_W-1:0]);
				end
				REG_COLS: begin
					grid_cols_q <= pwdata[DIM_W-1:0];
					cols_eff_q  <= (pwdata[DIM_W-1:0] == '0) ? CNT_W'(1) :
						(32'(pwdata[DIM_W-1:0]) > MAX_COLS) ? CNT_W'(MAX_COLS) :
						CNT_W'(pwdata[DIM_W-1:0]);
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = 32'(grid_rows_q);
			REG_COLS: prdata = 32'(grid_cols_q);
		endcase
	end

	// Decide whether the word takes part in the frame
	assign s_tready   = (int'(q_level) + RES_PER_ITEM * (1 + int'(v_s1) + int'(v_s2)))
		<= QUEUE_DEPTH;
	assign flush_in   = (s_tuser[0] == ACT_FLUSH);
	assign data_phase = (row_q < rows_eff_q);
	assign take       = s_tvalid && s_tready && (flush_in != data_phase);
	assign col_next   = CNT_W'(col_q) + CNT_W'(1);
	assign row_end    = (col_next >= cols_eff_q);
	assign final_in   = flush_in && row_end;
	assign bottom_in  = flush_in ? '0 : s_tdata[HEIGHT_BITS-1:0];

	// Advance the raster position; restart on the final flush or a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (final_in) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	// Hand the word to the window stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flush_s1   <= flush_in;
			row_end_s1 <= row_end;
			final_s1   <= final_in;
			c_s1       <= col_q;
			row_s1     <= row_q;
			bottom_s1  <= bottom_in;
		end
	end

	// Line buffer: upper half two rows up, lower half one row up
	gldp_line_buf #(
		.DEPTH  (MAX_COLS),
		.ADDR_W (COL_W),
		.DATA_W (2 * HEIGHT_BITS)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (col_q),
		.wr_en   (v_s1 && !flush_s1),
		.wr_addr (c_s1),
		.wr_data ({above, bottom_s1}),
		.rd_data (lb_rd)
	);

	assign two_above = lb_rd[2*HEIGHT_BITS-1:HEIGHT_BITS];
	assign above     = lb_rd[HEIGHT_BITS-1:0];

	// Shift the window left and bring in the new column
	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[0][k] <= win_q[1][k];
				win_q[1][k] <= win_q[2][k];
			end
			win_q[2][0] <= two_above;
			win_q[2][1] <= above;
			win_q[2][2] <= bottom_s1;
		end
	end

	// Hand the position to the test stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			flush_s2   <= flush_s1;
			row_end_s2 <= row_end_s1;
			final_s2   <= final_s1;
			c_s2       <= c_s1;
			row_s2     <= row_s1;
		end
	end

	// Test the middle column and, at the row end, the right column
	assign has_t = (32'(row_s2) >= 32'd2);

	gldp_peak_cmp #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_peak_mid (
		.left    (win_q[0]),
		.centre  (win_q[1]),
		.right   (win_q[2]),
		.has_l   (32'(c_s2) >= 32'd2),
		.has_r   (1'b1),
		.has_t   (has_t),
		.has_b   (!flush_s2),
		.is_peak (peak_a)
	);

	gldp_peak_cmp #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_peak_right (
		.left    (win_q[1]),
		.centre  (win_q[2]),
		.right   (win_q[2]),
		.has_l   (c_s2 != '0),
		.has_r   (1'b0),
		.has_t   (has_t),
		.has_b   (!flush_s2),
		.is_peak (peak_b)
	);

	assign hit_a   = v_s2 && (row_s2 != '0) && (c_s2 != '0) && peak_a;
	assign hit_b   = v_s2 && (row_s2 != '0) && row_end_s2 && peak_b;
	assign end_hit = v_s2 && final_s2;

	// Build the result words
	always_comb begin
		res_a            = '0;
		res_a.kind       = KIND_PEAK;
		res_a.row        = DIM_W'(row_s2);
		res_a.col        = DIM_W'(c_s2);
		res_b            = '0;
		res_b.kind       = KIND_PEAK;
		res_b.row        = DIM_W'(row_s2);
		res_b.col        = DIM_W'(CNT_W'(c_s2) + CNT_W'(1));
		res_e            = '0;
		res_e.kind       = KIND_END;
		res_e.none_found = !(peak_seen_q || hit_a || hit_b);
	end

	// Pack the words that occur and mark the last one
	assign push_cnt = {1'b0, hit_a} + {1'b0, hit_b} + {1'b0, end_hit};

	always_comb begin
		push_data[0] = hit_a ? res_a : (hit_b ? res_b : res_e);
		push_data[1] = (hit_a && hit_b) ? res_b : res_e;
		push_data[2] = res_e;
		for (int i = 0; i < RES_PER_ITEM; i++) begin
			push_data[i].last = (2'(i) == (push_cnt - 2'd1));
		end
	end

	// Track whether the frame has had a peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_seen_q <= 1'b0;
		end else if (cfg_wr || end_hit) begin
			peak_seen_q <= 1'b0;
		end else if (hit_a || hit_b) begin
			peak_seen_q <= 1'b1;
		end
	end

	// Output queue
	gldp_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.level     (q_level)
	);

	assign m_tvalid = (q_level != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {1'b0, head.none_found, head.col, head.row};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

endmodule

// File: rtl/gldp_line_buf.sv
// Two-row line buffer memory with registered read data and write-to-read forwarding.
module gldp_line_buf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [DATA_W-1:0] fwd_data_q;

	// Read old contents, write back the modified column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
	end

	// Remember whether a write landed on the edge of the last read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
		end
	end

	// Bypass the memory when the read raced a write to the same column
	assign rd_data = (fwd_valid_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : rd_q;

endmodule

// File: rtl/gldp_peak_cmp.sv
// Strict local-maximum test of a window centre against its existing neighbours.
module gldp_peak_cmp #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic signed [HEIGHT_BITS-1:0] left   [3],
	input  logic signed [HEIGHT_BITS-1:0] centre [3],
	input  logic signed [HEIGHT_BITS-1:0] right  [3],
	input  logic                          has_l,
	input  logic                          has_r,
	input  logic                          has_t,
	input  logic                          has_b,
	output logic                          is_peak
);

	logic signed [HEIGHT_BITS-1:0] v;

	assign v = centre[1];

	// Drop the candidate on any neighbour that is not strictly lower
	always_comb begin
		is_peak = 1'b1;
		if (has_t) begin
			if (!(v > centre[0])) is_peak = 1'b0;
			if (has_l && !(v > left[0])) is_peak = 1'b0;
			if (has_r && !(v > right[0])) is_peak = 1'b0;
		end
		if (has_l && !(v > left[1])) is_peak = 1'b0;
		if (has_r && !(v > right[1])) is_peak = 1'b0;
		if (has_b) begin
			if (!(v > centre[2])) is_peak = 1'b0;
			if (has_l && !(v > left[2])) is_peak = 1'b0;
			if (has_r && !(v > right[2])) is_peak = 1'b0;
		end
	end

endmodule

// File: rtl/gldp_res_queue.sv
// Result queue taking up to three words per cycle and giving at most one.
module gldp_res_queue
	import gldp_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [1:0]                         push_cnt,
	input  gldp_res_t                          push_data [RES_PER_ITEM],
	input  logic                               pop,
	output gldp_res_t                          head,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   level
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	gldp_res_t        mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	// Store the new words at consecutive slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_PER_ITEM; i++) begin
			if (i < int'(push_cnt)) begin
				mem[wr_ptr_q + PTR_W'(i)] <= push_data[i];
			end
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + LVL_W'(push_cnt) - LVL_W'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign level = level_q;

endmodule

// File: tb/tb_grid_local_peak_detector_unit.sv
// Self-checking testbench of the grid local peak detector: stimulus, peak predictor, checks.
`timescale 1ns / 1ps

module tb_grid_local_peak_detector_unit;
	import gldp_pkg::*;

	localparam logic [2:0] ADDR_ROWS   = 3'd0;
	localparam logic [2:0] ADDR_COLS   = 3'd4;
	localparam logic       ACT_CELL    = 1'b0;
	localparam logic       ACT_FLUSH   = 1'b1;
	localparam logic       KIND_PEAK   = 1'b0;
	localparam logic       KIND_EOF    = 1'b1;
	localparam int         DRAIN_CYC   = 8;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         RAND_ITEMS  = 320;
	localparam int         PRESS_HOLD  = 200;
	localparam int         NDIR        = 23;

	typedef enum logic [1:0] {OP_RD, OP_WR, OP_ITEM, OP_ITEM_T} op_e;

	// One row of the directed table; typed results apply to OP_ITEM_T only
	typedef struct packed {
		op_e         op;
		logic [2:0]  addr;
		logic [31:0] val;
		logic        act;
		logic [15:0] hgt;
		logic [1:0]  n_res;
		gldp_res_t   r0;
		gldp_res_t   r1;
	} stim_t;

	localparam gldp_res_t NO_RES = '0;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;  // height
	logic [0:0]  s_tuser   = '0;  // action
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;         // peak_row, peak_col, none_found
	logic [0:0]  m_tuser;         // kind
	logic        m_tlast;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	grid_local_peak_detector_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Predictor state: registers, two line stores, 3x3 neighbourhood, raster position
	logic [DIM_W-1:0]   rows_reg;
	logic [DIM_W-1:0]   cols_reg;
	logic signed [15:0] line_above     [0:MAX_COLS_DEF-1];
	logic signed [15:0] line_two_above [0:MAX_COLS_DEF-1];
	logic signed [15:0] nbhd [0:2][0:2];
	int                 col_pos;
	int                 row_pos;
	bit                 any_peak;

	gldp_res_t due_reports[$];
	int        err_cnt   = 0;
	int        cycle_cnt = 0;
	bit        tx_fast   = 1'b0;
	bit        tx_nogap  = 1'b0;
	bit        rx_fast   = 1'b0;
	int        rx_hold   = 0;
	gldp_res_t want;
	gldp_res_t got;
	stim_t     dir_tbl [0:NDIR-1];

	// Clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic gldp_res_t mk_res(input logic kind, input int row, input int col,
			input logic none, input logic last);
		gldp_res_t r;
		r.kind       = kind;
		r.row        = row[DIM_W-1:0];
		r.col        = col[DIM_W-1:0];
		r.none_found = none;
		r.last       = last;
		return r;
	endfunction

	// Zero and above the maximum both fold into the legal range
	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
		if (v == 0)
			return 1;
		if (v > max_dim)
			return max_dim;
		return v;
	endfunction

	function automatic void clear_frame();
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				nbhd[i][j] = '0;
		col_pos  = 0;
		row_pos  = 0;
		any_peak = 1'b0;
	endfunction

	// Centre column cc of the neighbourhood against every neighbour that exists
	function automatic bit beats_nbrs(input int cc, input bit has_l, input bit has_r,
			input bit has_t, input bit has_b);
		logic signed [15:0] v;
		v = nbhd[1][cc];
		for (int dr = -1; dr <= 1; dr++) begin
			if ((dr < 0 && !has_t) || (dr > 0 && !has_b))
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr == 0 && dc == 0)
					continue;
				if ((dc < 0 && !has_l) || (dc > 0 && !has_r))
					continue;
				if (!(v > nbhd[1 + dr][cc + dc]))
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Advance the predictor by one accepted word and return the reports it causes
	task automatic find_peaks(input logic act, input logic [15:0] hgt,
			output gldp_res_t [RES_PER_ITEM-1:0] outs, output int n);
		int rows;
		int cols;
		int c;
		bit flush;
		bit has_t;
		bit has_b;
		bit row_end;
		n    = 0;
		outs = '0;
		rows = eff_dim(rows_reg, MAX_ROWS_DEF);
		cols = eff_dim(cols_reg, MAX_COLS_DEF);
		flush = (act == ACT_FLUSH);
		// Drop cells past the last row and flush words before it
		if (flush == (row_pos < rows))
			return;
		c = col_pos;
		for (int k = 0; k < 3; k++) begin
			nbhd[k][0] = nbhd[k][1];
			nbhd[k][1] = nbhd[k][2];
		end
		nbhd[0][2] = line_two_above[c];
		nbhd[1][2] = line_above[c];
		nbhd[2][2] = flush ? 16'sd0 : $signed(hgt);
		if (!flush) begin
			line_two_above[c] = line_above[c];
			line_above[c]     = hgt;
		end
		has_t   = row_pos >= 2;
		has_b   = !flush;
		row_end = (c + 1 >= cols);
		if (row_pos >= 1) begin
			if (c >= 1 && beats_nbrs(1, c >= 2, 1'b1, has_t, has_b)) begin
				outs[n] = mk_res(KIND_PEAK, row_pos, c, 1'b0, 1'b0);
				n++;
				any_peak = 1'b1;
			end
			if (row_end && beats_nbrs(2, c >= 1, 1'b0, has_t, has_b)) begin
				outs[n] = mk_res(KIND_PEAK, row_pos, c + 1, 1'b0, 1'b0);
				n++;
				any_peak = 1'b1;
			end
		end
		if (row_end) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos = c + 1;
		end
		if (flush && row_end) begin
			outs[n] = mk_res(KIND_EOF, 0, 0, !any_peak, 1'b0);
			n++;
			clear_frame();
		end
		if (n > 0)
			outs[n-1].last = 1'b1;
	endtask

	// Offer one word after a random gap and hold it until it is taken
	task automatic offer_word(input logic act, input logic [15:0] hgt);
		int gap;
		gap = (tx_nogap || tx_fast) ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 23) == 0)
			tx_fast = !tx_fast;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= hgt;
		s_tuser  <= act;
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	task automatic feed_word(input logic act, input logic [15:0] hgt);
		gldp_res_t [RES_PER_ITEM-1:0] outs;
		int n;
		offer_word(act, hgt);
		find_peaks(act, hgt, outs, n);
		for (int k = 0; k < n; k++)
			due_reports.push_back(outs[k]);
	endtask

	// Drop valid, wait for every report, then let words in flight settle
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input logic [2:0] addr, input logic [31:0] exp_val);
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== exp_val) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("register %0d: expected %h, got %h", addr, exp_val, rd);
		end
	endtask

	// Write a size register while idle, restart the predicted frame, read it back
	task automatic set_reg(input logic [2:0] addr, input logic [31:0] val);
		wait_idle();
		apb_write(addr, val);
		if (addr == ADDR_ROWS)
			rows_reg = val[DIM_W-1:0];
		else
			cols_reg = val[DIM_W-1:0];
		clear_frame();
		check_reg(addr, {21'd0, val[DIM_W-1:0]});
	endtask

	// Heights: extremes, a narrow band that produces ties, full range
	function automatic logic [15:0] pick_height();
		case ($urandom_range(0, 9))
			0:          return 16'h8000;
			1:          return 16'h7fff;
			2, 3, 4, 5: return $urandom_range(0, 6) - 3;
			default:    return $urandom;
		endcase
	endfunction

	// Send one frame in raster order, then one flush word per column
	task automatic run_frame(input int rows, input int cols, input bit noisy,
			input bit patterned, input int cut_at, input int pause_at, output int sent);
		int total;
		int r;
		int c;
		bit is_flush;
		logic [15:0] h;
		sent  = 0;
		total = rows * cols + cols;
		for (int i = 0; i < total; i++) begin
			is_flush = i >= rows * cols;
			r = i / cols;
			c = i % cols;
			// Slip in a word of the wrong kind now and then
			if (noisy && $urandom_range(0, 11) == 0)
				feed_word(is_flush ? ACT_CELL : ACT_FLUSH, $urandom);
			if (is_flush)
				h = $urandom;
			else if (patterned)
				h = (r % 2 == 0 && c % 2 == 0) ? 1000 + $urandom_range(0, 99)
					: $urandom_range(0, 99);
			else
				h = pick_height();
			feed_word(is_flush ? ACT_FLUSH : ACT_CELL, h);
			sent++;
			if (sent == cut_at)
				return;
			if (sent == pause_at)
				wait_idle();
		end
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Check each accepted result word against the oldest predicted report
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_reports.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected word: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				want = due_reports.pop_front();
				got  = {m_tuser[0], m_tdata[10:0], m_tdata[21:11], m_tdata[22], m_tlast};
				if (got !== want || m_tdata[23] !== 1'b0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("kind/row/col/none/last/pad expected %0d %0d %0d %0d %0d 0, got %0d %0d %0d %0d %0d %0d",
							want.kind, want.row, want.col, want.none_found, want.last,
							got.kind, got.row, got.col, got.none_found, got.last,
							m_tdata[23]);
				end
			end
		end
	end

	// Result side: random stalls per word, plus one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_fast ? 0 : $urandom_range(0, 7);
			end
			if ($urandom_range(0, 19) == 0)
				rx_fast = !rx_fast;
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// Main sequence
	initial begin
		stim_t ent;
		gldp_res_t [RES_PER_ITEM-1:0] outs;
		int n;
		int sent;
		int rnd_items;
		int pick;
		int rows;
		int cols;
		int total;
		int cut_at;
		int pause_at;
		bit must_write;

		rows_reg = GRID_RST;
		cols_reg = GRID_RST;
		for (int i = 0; i < MAX_COLS_DEF; i++) begin
			line_above[i]     = '0;
			line_two_above[i] = '0;
		end
		clear_frame();

		dir_tbl = '{
			// Reset sizes, a few cells of the default grid, an early flush
			'{OP_RD,     ADDR_ROWS, 32'd1024, ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_RD,     ADDR_COLS, 32'd1024, ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_CELL,  16'h7fff, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_CELL,  16'h8000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_FLUSH, 16'h5a5a, 2'd0, NO_RES, NO_RES},
			// 1x1 grid with rows written as zero: the single cell is a peak
			'{OP_WR,     ADDR_ROWS, 32'd0,    ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_WR,     ADDR_COLS, 32'd1,    ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_CELL,  16'h8000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_CELL,  16'd1234, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_FLUSH, 16'hffff, 2'd2,
				mk_res(KIND_PEAK, 1, 1, 1'b0, 1'b0), mk_res(KIND_EOF, 0, 0, 1'b0, 1'b1)},
			// 1x2 grid of equal cells: no peak in the frame
			'{OP_WR,     ADDR_COLS, 32'd2,    ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_CELL,  16'd7,    2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_CELL,  16'd7,    2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_FLUSH, 16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM_T, ADDR_ROWS, 32'd0,    ACT_FLUSH, 16'hffff, 2'd1,
				mk_res(KIND_EOF, 0, 0, 1'b1, 1'b1), NO_RES},
			// 2x2 grid of extreme heights
			'{OP_WR,     ADDR_ROWS, 32'd2,    ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_WR,     ADDR_COLS, 32'd2,    ACT_CELL,  16'h0000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM,   ADDR_ROWS, 32'd0,    ACT_CELL,  16'h8000, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM,   ADDR_ROWS, 32'd0,    ACT_CELL,  16'h8001, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM,   ADDR_ROWS, 32'd0,    ACT_CELL,  16'h7fff, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM,   ADDR_ROWS, 32'd0,    ACT_CELL,  16'h5555, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM,   ADDR_ROWS, 32'd0,    ACT_FLUSH, 16'haaaa, 2'd0, NO_RES, NO_RES},
			'{OP_ITEM,   ADDR_ROWS, 32'd0,    ACT_FLUSH, 16'h0000, 2'd0, NO_RES, NO_RES}
		};

		// Reset
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < NDIR; i++) begin
			ent = dir_tbl[i];
			case (ent.op)
				OP_RD: begin
					wait_idle();
					check_reg(ent.addr, ent.val);
				end
				OP_WR:   set_reg(ent.addr, ent.val);
				OP_ITEM: feed_word(ent.act, ent.hgt);
				default: begin
					// Advance the predictor, but expect the typed reports
					offer_word(ent.act, ent.hgt);
					find_peaks(ent.act, ent.hgt, outs, n);
					if (ent.n_res > 0)
						due_reports.push_back(ent.r0);
					if (ent.n_res > 1)
						due_reports.push_back(ent.r1);
				end
			endcase
		end

		// Largest sizes: one tall single column, one wide single row
		set_reg(ADDR_ROWS, 32'd2047);
		set_reg(ADDR_COLS, 32'd1);
		run_frame(eff_dim(rows_reg, MAX_ROWS_DEF), 1, 1'b0, 1'b0, 0, 0, sent);
		set_reg(ADDR_ROWS, 32'd1);
		set_reg(ADDR_COLS, 32'd1024);
		run_frame(1, eff_dim(cols_reg, MAX_COLS_DEF), 1'b0, 1'b0, 0, 0, sent);

		// Dense peaks, no input gaps and a long output hold-off; pause mid-frame once
		set_reg(ADDR_ROWS, 32'd8);
		set_reg(ADDR_COLS, 32'd8);
		tx_nogap = 1'b1;
		rx_hold  = PRESS_HOLD;
		run_frame(8, 8, 1'b0, 1'b1, 0, 40, sent);
		wait_idle();
		tx_nogap = 1'b0;

		// Random frames of small sizes, some cut short and restarted by a write
		rnd_items  = 0;
		must_write = 1'b1;
		while (rnd_items < RAND_ITEMS) begin
			pick = $urandom_range(0, 3);
			if (must_write || pick == 0 || pick == 1)
				set_reg(ADDR_ROWS, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
			if (must_write || pick == 0 || pick == 2)
				set_reg(ADDR_COLS, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
			rows     = eff_dim(rows_reg, MAX_ROWS_DEF);
			cols     = eff_dim(cols_reg, MAX_COLS_DEF);
			total    = rows * cols + cols;
			cut_at   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : 0;
			pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total) : 0;
			run_frame(rows, cols, 1'b1, 1'b0, cut_at, pause_at, sent);
			rnd_items += sent;
			must_write = (cut_at != 0);
		end

		// Drain and report
		wait_idle();
		if (err_cnt == 0 && due_reports.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
